### sv/cpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_pkg - shared types and constants of the client presence table
// Entry record layout, opcodes, presence codes, sequencer states and the
// saturating counter helper.
// ---------------------------------------------------------------------------
package cpt_pkg;

  localparam int ADDR_W    = 48;
  localparam int CTR_W     = 7;
  localparam int STR_W     = 8;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CTR_W-1:0] SAT_MAX   = 7'd127;
  localparam logic [CTR_W-1:0] LIMIT_RST = 7'd2;

  // register index decoded from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_SIGHT  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PS_OFFLINE     = 2'd0,
    PS_ONLINE      = 2'd1,
    PS_NEW_OFFLINE = 2'd2,
    PS_RECONNECT   = 2'd3
  } presence_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    presence_t         pstate;
    logic [CTR_W-1:0]  missed;
    logic [STR_W-1:0]  strength;
  } entry_t;

  // per-entry outcome of the update unit
  typedef struct packed {
    logic wr;
    logic hit;
    logic disc;
    logic recon;
  } upd_ctl_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v < SAT_MAX) ? CTR_W'(v + 1'b1) : SAT_MAX;
  endfunction

endpackage

### sv/client_presence_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// client_presence_table_top - client presence table
// Station address table with presence state, missed-tick aging, sighting
// lookup and saturating disconnect and reconnect counters.
// ---------------------------------------------------------------------------
// results: insert and unused opcode report in the cycle after the request; tick and
//   sighting walk the filled entries one per cycle through the update unit and
//   report when a hit is found or the last filled entry has been processed
// requests: busy stays high during a walk, so no new request is taken until it ends;
//   after an insert the next request can be taken in the following cycle
// reset: table empty, counters zero, timeout_limit 2; entry store not cleared
// ---------------------------------------------------------------------------
module client_presence_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic [cpt_pkg::ADDR_W-1:0]          in_station_address,
  input  logic signed [cpt_pkg::STR_W-1:0]    in_signal_strength,
  // result channel
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic [cpt_pkg::IDX_OUT_W-1:0]       out_entry_index,
  output logic [1:0]                          out_entry_state,
  output logic [cpt_pkg::CNT_OUT_W-1:0]       out_client_count,
  output logic [cpt_pkg::CTR_W-1:0]           out_disconnect_total,
  output logic [cpt_pkg::CTR_W-1:0]           out_reconnect_total,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpt_pkg::PADDR_W-1:0]         paddr,
  input  logic [cpt_pkg::PDATA_W-1:0]         pwdata,
  output logic [cpt_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [cpt_pkg::CTR_W-1:0] limit_r, limit_nxt;
  logic                      cfg_wr;
  logic                      cfg_sel;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  cpt_pkg::entry_t   mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  cpt_pkg::entry_t   mem_rdata;

  // register decode
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[cpt_pkg::PADDR_W-1] == cpt_pkg::REG_TIMEOUT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

  assign limit_nxt = cfg_wr ? pwdata[cpt_pkg::CTR_W-1:0] : limit_r;

  // timeout limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cpt_pkg::LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // read back
  assign prdata = cfg_sel ? cpt_pkg::PDATA_W'(limit_r) : '0;

  // entry store
  cpt_entry_ram #(
    .DEPTH (ENTRIES),
    .IW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  cpt_ctrl #(
    .ENTRIES (ENTRIES),
    .CW      (CW),
    .IW      (IW)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_station_address   (in_station_address),
    .in_signal_strength   (in_signal_strength),
    .limit                (limit_r),
    .mem_we               (mem_we),
    .mem_waddr            (mem_waddr),
    .mem_wdata            (mem_wdata),
    .mem_re               (mem_re),
    .mem_raddr            (mem_raddr),
    .mem_rdata            (mem_rdata),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_entry_index      (out_entry_index),
    .out_entry_state      (out_entry_state),
    .out_client_count     (out_client_count),
    .out_disconnect_total (out_disconnect_total),
    .out_reconnect_total  (out_reconnect_total)
  );

endmodule

### sv/cpt_entry_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_entry_ram - entry record store
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cpt_entry_ram #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  cpt_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr,
  output cpt_pkg::entry_t   rdata
);

  cpt_pkg::entry_t mem [DEPTH];
  cpt_pkg::entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/cpt_entry_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_entry_unit - shared compare and update unit
// Applies an aging tick or a sighting to one entry record per cycle.
// ---------------------------------------------------------------------------
module cpt_entry_unit (
  input  cpt_pkg::opcode_t                 op,
  input  logic [cpt_pkg::ADDR_W-1:0]       addr,
  input  logic [cpt_pkg::STR_W-1:0]        strength,
  input  logic [cpt_pkg::CTR_W-1:0]        limit,
  input  cpt_pkg::entry_t                  entry_in,
  output cpt_pkg::entry_t                  entry_out,
  output cpt_pkg::upd_ctl_t                ctl
);

  logic [cpt_pkg::CTR_W-1:0] missed_inc;

  // missed count raised up to the limit
  assign missed_inc = (entry_in.missed < limit) ? cpt_pkg::CTR_W'(entry_in.missed + 1'b1)
                                                : entry_in.missed;

  // per-entry update
  always_comb begin
    entry_out = entry_in;
    ctl       = '0;
    case (op)
      cpt_pkg::OP_TICK: begin
        ctl.wr             = 1'b1;
        entry_out.strength = '0;
        if (entry_in.pstate != cpt_pkg::PS_OFFLINE) begin
          entry_out.missed = missed_inc;
          if (missed_inc >= limit) begin
            ctl.disc         = 1'b1;
            entry_out.pstate = cpt_pkg::PS_NEW_OFFLINE;
          end
        end
      end
      cpt_pkg::OP_SIGHT: begin
        if (entry_in.addr == addr) begin
          ctl.wr             = 1'b1;
          ctl.hit            = 1'b1;
          entry_out.strength = strength;
          entry_out.missed   = '0;
          if (entry_in.missed >= limit) begin
            ctl.recon        = 1'b1;
            entry_out.pstate = cpt_pkg::PS_RECONNECT;
          end else begin
            entry_out.pstate = cpt_pkg::PS_ONLINE;
          end
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

### sv/cpt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_ctrl - request sequencer of the client presence table
// Handles inserts directly and walks the stored entries through the shared
// update unit for ticks and sightings; keeps the fill count and counters.
// ---------------------------------------------------------------------------
module cpt_ctrl #(
  parameter int ENTRIES = 16,
  parameter int CW      = 5,
  parameter int IW      = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_opcode,
  input  logic [cpt_pkg::ADDR_W-1:0]       in_station_address,
  input  logic signed [cpt_pkg::STR_W-1:0] in_signal_strength,
  input  logic [cpt_pkg::CTR_W-1:0]        limit,
  // entry store
  output logic                             mem_we,
  output logic [IW-1:0]                    mem_waddr,
  output cpt_pkg::entry_t                  mem_wdata,
  output logic                             mem_re,
  output logic [IW-1:0]                    mem_raddr,
  input  cpt_pkg::entry_t                  mem_rdata,
  // result
  output logic                             out_valid,
  output logic                             out_accepted,
  output logic [cpt_pkg::IDX_OUT_W-1:0]    out_entry_index,
  output logic [1:0]                       out_entry_state,
  output logic [cpt_pkg::CNT_OUT_W-1:0]    out_client_count,
  output logic [cpt_pkg::CTR_W-1:0]        out_disconnect_total,
  output logic [cpt_pkg::CTR_W-1:0]        out_reconnect_total
);

  localparam int IdxOutW = cpt_pkg::IDX_OUT_W;
  localparam int CntOutW = cpt_pkg::CNT_OUT_W;
  localparam logic [CW-1:0] Full = CW'(ENTRIES);

  cpt_pkg::seq_state_t state_r, state_nxt;
  cpt_pkg::opcode_t    op_r, op_nxt;
  logic [cpt_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [cpt_pkg::STR_W-1:0]  str_r, str_nxt;
  logic [CW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [cpt_pkg::CTR_W-1:0] disc_r, disc_nxt;
  logic [cpt_pkg::CTR_W-1:0] recon_r, recon_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic [IdxOutW-1:0]   out_idx_r, out_idx_nxt;
  logic [1:0]           out_st_r, out_st_nxt;
  logic [CntOutW-1:0]   out_cnt_r, out_cnt_nxt;
  logic [cpt_pkg::CTR_W-1:0] out_disc_r, out_disc_nxt;
  logic [cpt_pkg::CTR_W-1:0] out_recon_r, out_recon_nxt;

  cpt_pkg::opcode_t    in_op;
  cpt_pkg::entry_t     upd_entry;
  cpt_pkg::upd_ctl_t   upd_ctl;
  logic                accept;

  assign in_op  = cpt_pkg::opcode_t'(in_opcode);
  assign busy   = (state_r != cpt_pkg::ST_IDLE);
  assign accept = start && !busy;

  // shared update unit
  cpt_entry_unit u_unit (
    .op        (op_r),
    .addr      (addr_r),
    .strength  (str_r),
    .limit     (limit),
    .entry_in  (mem_rdata),
    .entry_out (upd_entry),
    .ctl       (upd_ctl)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpt_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      disc_r      <= '0;
      recon_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      disc_r      <= disc_nxt;
      recon_r     <= recon_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    str_r       <= str_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_acc_r   <= out_acc_nxt;
    out_idx_r   <= out_idx_nxt;
    out_st_r    <= out_st_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_disc_r  <= out_disc_nxt;
    out_recon_r <= out_recon_nxt;
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    str_nxt       = str_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    cnt_nxt       = cnt_r;
    disc_nxt      = disc_r;
    recon_nxt     = recon_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_idx_r;
    mem_wdata     = upd_entry;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r[IW-1:0];
    out_valid_nxt = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    out_disc_nxt  = out_disc_r;
    out_recon_nxt = out_recon_r;

    case (state_r)
      cpt_pkg::ST_IDLE: begin
        if (accept) begin
          out_acc_nxt = 1'b0;
          out_idx_nxt = '0;
          out_st_nxt  = cpt_pkg::PS_OFFLINE;
          case (in_op)
            // insert appends at the fill count
            cpt_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (cnt_r < Full) begin
                mem_we             = 1'b1;
                mem_waddr          = cnt_r[IW-1:0];
                mem_wdata.addr     = in_station_address;
                mem_wdata.pstate   = cpt_pkg::PS_OFFLINE;
                mem_wdata.missed   = limit;
                mem_wdata.strength = '0;
                cnt_nxt            = CW'(cnt_r + 1'b1);
                out_acc_nxt        = 1'b1;
                out_idx_nxt        = IdxOutW'(cnt_r);
              end
            end
            // tick and sighting walk the table
            cpt_pkg::OP_TICK, cpt_pkg::OP_SIGHT: begin
              op_nxt     = in_op;
              addr_nxt   = in_station_address;
              str_nxt    = in_signal_strength;
              rd_ptr_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = cpt_pkg::ST_WALK;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      cpt_pkg::ST_WALK: begin
        // issue the next read
        if (rd_ptr_r < cnt_r) begin
          mem_re       = 1'b1;
          rd_ptr_nxt   = CW'(rd_ptr_r + 1'b1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_ptr_r[IW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        // process the entry read last cycle
        if (pend_r) begin
          mem_we = upd_ctl.wr;
          if (upd_ctl.disc) begin
            disc_nxt = cpt_pkg::sat_inc(disc_r);
          end
          if (upd_ctl.recon) begin
            recon_nxt = cpt_pkg::sat_inc(recon_r);
          end
          if (upd_ctl.hit) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b1;
            out_idx_nxt   = IdxOutW'(pend_idx_r);
            out_st_nxt    = upd_entry.pstate;
            pend_nxt      = 1'b0;
            state_nxt     = cpt_pkg::ST_IDLE;
          end
        end else if (rd_ptr_r >= cnt_r) begin
          // walk finished without a hit
          out_valid_nxt = 1'b1;
          out_acc_nxt   = (op_r == cpt_pkg::OP_TICK);
          out_idx_nxt   = '0;
          out_st_nxt    = cpt_pkg::PS_OFFLINE;
          state_nxt     = cpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpt_pkg::ST_IDLE;
      end
    endcase

    // counts after the request go with the result
    if (out_valid_nxt) begin
      out_cnt_nxt   = CntOutW'(cnt_nxt);
      out_disc_nxt  = disc_nxt;
      out_recon_nxt = recon_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_acc_r;
  assign out_entry_index      = out_idx_r;
  assign out_entry_state      = out_st_r;
  assign out_client_count     = out_cnt_r;
  assign out_disconnect_total = out_disc_r;
  assign out_reconnect_total  = out_recon_r;

  // fill count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Full)
    else $error("fill count beyond table size");

  // stores only touch filled entries or the next free one
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) <= cnt_r))
    else $error("entry write beyond fill count");

  // a pending read only exists during a walk
  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == cpt_pkg::ST_WALK))
    else $error("pending read outside walk");

  // a result strobe is only seen while the sequencer is idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == cpt_pkg::ST_IDLE))
    else $error("result while still walking");

  // a refused or missed request reports index and state zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_acc_r) |-> (out_idx_r == '0 && out_st_r == cpt_pkg::PS_OFFLINE))
    else $error("nonzero index on refused request");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - client presence table
// Drives insert, aging tick, sighting and unused-opcode requests into the
// table under several timeout limits and checks every result strobe against
// a cycle-free model of the table, with random gaps between requests.
// ---------------------------------------------------------------------------
module testbench;

  localparam int ENTRIES        = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 98;
  localparam int QUIET_LIMIT    = 1000;
  localparam logic [cpt_pkg::PADDR_W-1:0] TIMEOUT_ADDR = {cpt_pkg::REG_TIMEOUT, 2'b00};

  // one result strobe
  typedef struct packed {
    logic                          accepted;
    logic [cpt_pkg::IDX_OUT_W-1:0] index;
    cpt_pkg::presence_t            state;
    logic [cpt_pkg::CNT_OUT_W-1:0] clients;
    logic [cpt_pkg::CTR_W-1:0]     disc;
    logic [cpt_pkg::CTR_W-1:0]     recon;
  } station_report_t;

  // table model and queue of reports still owed by the block
  class presence_tracker;
    logic [cpt_pkg::ADDR_W-1:0] stn_addr[ENTRIES];
    cpt_pkg::presence_t         stn_state[ENTRIES];
    logic [cpt_pkg::CTR_W-1:0]  stn_missed[ENTRIES];
    int                         clients;
    logic [cpt_pkg::CTR_W-1:0]  disc;
    logic [cpt_pkg::CTR_W-1:0]  recon;
    logic [cpt_pkg::CTR_W-1:0]  limit;
    station_report_t            owed_reports[$];
    int errors, n_requests, n_refused, n_hits, n_misses, n_ticks;

    function new();
      foreach (stn_addr[i]) begin
        stn_addr[i]   = '0;
        stn_state[i]  = cpt_pkg::PS_OFFLINE;
        stn_missed[i] = '0;
      end
      clients = 0;
      disc    = '0;
      recon   = '0;
      limit   = cpt_pkg::LIMIT_RST;
    endfunction

    function void set_limit(logic [cpt_pkg::CTR_W-1:0] value);
      limit = value;
    endfunction

    // update the table for an accepted request; strength is stored by the
    // block but never reported, so it is not tracked here
    function void note_request(cpt_pkg::opcode_t op, logic [cpt_pkg::ADDR_W-1:0] addr);
      station_report_t r;
      r = '0;
      n_requests++;
      case (op)
        cpt_pkg::OP_INSERT: begin
          if (clients < ENTRIES) begin
            stn_addr[clients]   = addr;
            stn_state[clients]  = cpt_pkg::PS_OFFLINE;
            stn_missed[clients] = limit;
            r.accepted = 1'b1;
            r.index    = cpt_pkg::IDX_OUT_W'(clients);
            clients++;
          end else begin
            n_refused++;
          end
        end
        cpt_pkg::OP_TICK: begin
          n_ticks++;
          for (int i = 0; i < clients; i++) begin
            if (stn_state[i] != cpt_pkg::PS_OFFLINE) begin
              if (stn_missed[i] < limit) stn_missed[i]++;
              if (stn_missed[i] >= limit) begin
                if (disc < cpt_pkg::SAT_MAX) disc++;
                stn_state[i] = cpt_pkg::PS_NEW_OFFLINE;
              end
            end
          end
          r.accepted = 1'b1;
        end
        cpt_pkg::OP_SIGHT: begin
          // first matching entry wins
          for (int i = 0; i < clients && !r.accepted; i++) begin
            if (stn_addr[i] == addr) begin
              stn_state[i] = cpt_pkg::PS_ONLINE;
              if (stn_missed[i] >= limit) begin
                stn_state[i] = cpt_pkg::PS_RECONNECT;
                if (recon < cpt_pkg::SAT_MAX) recon++;
              end
              stn_missed[i] = '0;
              r.accepted = 1'b1;
              r.index    = cpt_pkg::IDX_OUT_W'(i);
              r.state    = stn_state[i];
            end
          end
          if (r.accepted) n_hits++;
          else n_misses++;
        end
        default: ;
      endcase
      r.clients = cpt_pkg::CNT_OUT_W'(clients);
      r.disc    = disc;
      r.recon   = recon;
      owed_reports.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic acc, logic [cpt_pkg::IDX_OUT_W-1:0] idx,
                               logic [1:0] st, logic [cpt_pkg::CNT_OUT_W-1:0] cnt,
                               logic [cpt_pkg::CTR_W-1:0] dt,
                               logic [cpt_pkg::CTR_W-1:0] rt);
      station_report_t r;
      if (owed_reports.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      r = owed_reports.pop_front();
      compare("accepted", 32'(r.accepted), 32'(acc));
      compare("entry_index", 32'(r.index), 32'(idx));
      compare("entry_state", 32'(r.state), 32'(st));
      compare("client_count", 32'(r.clients), 32'(cnt));
      compare("disconnect_total", 32'(r.disc), 32'(dt));
      compare("reconnect_total", 32'(r.recon), 32'(rt));
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_opcode = cpt_pkg::OP_NONE;
  logic [cpt_pkg::ADDR_W-1:0]        in_station_address = '0;
  logic signed [cpt_pkg::STR_W-1:0]  in_signal_strength = '0;
  logic                              out_valid;
  logic                              out_accepted;
  logic [cpt_pkg::IDX_OUT_W-1:0]     out_entry_index;
  logic [1:0]                        out_entry_state;
  logic [cpt_pkg::CNT_OUT_W-1:0]     out_client_count;
  logic [cpt_pkg::CTR_W-1:0]         out_disconnect_total;
  logic [cpt_pkg::CTR_W-1:0]         out_reconnect_total;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [cpt_pkg::PADDR_W-1:0]       paddr = '0;
  logic [cpt_pkg::PDATA_W-1:0]       pwdata = '0;
  logic [cpt_pkg::PDATA_W-1:0]       prdata;
  logic                              pready;

  presence_tracker            tracker = new();
  logic [cpt_pkg::ADDR_W-1:0] known_stations[$];
  int                         quiet_cycles = 0;

  client_presence_table_top #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_station_address   (in_station_address),
    .in_signal_strength   (in_signal_strength),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_entry_index      (out_entry_index),
    .out_entry_state      (out_entry_state),
    .out_client_count     (out_client_count),
    .out_disconnect_total (out_disconnect_total),
    .out_reconnect_total  (out_reconnect_total),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // sample results and accepted requests at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        tracker.check_result(out_accepted, out_entry_index, out_entry_state,
                             out_client_count, out_disconnect_total,
                             out_reconnect_total);
      end
      if (start && !busy) begin
        tracker.note_request(cpt_pkg::opcode_t'(in_opcode), in_station_address);
      end
      if (out_valid || (start && !busy) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any traffic
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no traffic for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // present one request and hold it until accepted
  task automatic send_request(input cpt_pkg::opcode_t op,
                              input logic [cpt_pkg::ADDR_W-1:0] addr,
                              input logic [cpt_pkg::STR_W-1:0] strength,
                              input bit allow_gaps);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start              <= 1'b1;
    in_opcode          <= op;
    in_station_address <= addr;
    in_signal_strength <= strength;
    if (op == cpt_pkg::OP_INSERT && known_stations.size() < ENTRIES) begin
      known_stations.push_back(addr);
    end
    do @(posedge clk); while (busy);
  endtask

  // mostly sightings of stored stations, with ticks, inserts and noise
  task automatic random_request(input bit allow_gaps);
    int                         roll;
    int                         pick;
    cpt_pkg::opcode_t           op;
    logic [cpt_pkg::ADDR_W-1:0] addr;
    roll = $urandom_range(0, 99);
    addr = {16'($urandom()), 32'($urandom())};
    if (roll < 12) begin
      op = cpt_pkg::OP_INSERT;
      if (known_stations.size() != 0 && $urandom_range(0, 4) == 0)
        addr = known_stations[$urandom_range(0, known_stations.size() - 1)];
    end else if (roll < 40) begin
      op = cpt_pkg::OP_TICK;
    end else if (roll < 96) begin
      op = cpt_pkg::OP_SIGHT;
      pick = $urandom_range(0, 9);
      if (known_stations.size() != 0 && pick < 8) begin
        addr = known_stations[$urandom_range(0, known_stations.size() - 1)];
        // near miss: one address bit off
        if (pick == 7) addr[$urandom_range(0, cpt_pkg::ADDR_W - 1)] ^= 1'b1;
      end
    end else begin
      op = cpt_pkg::OP_NONE;
    end
    send_request(op, addr, cpt_pkg::STR_W'($urandom()), allow_gaps);
  endtask

  // let every outstanding request report before touching the register;
  // the first edge makes sure the last accepted request has been noted
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.owed_reports.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write the timeout limit, then read it back
  task automatic set_timeout(input logic [cpt_pkg::CTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= cpt_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_limit(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cpt_pkg::PDATA_W'(value)) begin
      $error("timeout_limit readback: expected %0d, got %0d", value, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [cpt_pkg::CTR_W-1:0] limit_plan[PHASES];
    limit_plan = '{7'd127, 7'd1, 7'd0, 7'd2, 7'd3, 7'd127, 7'd1, 7'd3};
    limit_plan[4] = cpt_pkg::CTR_W'($urandom_range(3, 126));
    limit_plan[7] = cpt_pkg::CTR_W'($urandom_range(3, 126));

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, aging and reconnects
    send_request(cpt_pkg::OP_SIGHT, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1);
    send_request(cpt_pkg::OP_NONE, 48'h1234_5678_9ABC, 8'h7F, 1'b1);
    send_request(cpt_pkg::OP_INSERT, 48'h0, 8'h80, 1'b1);
    send_request(cpt_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_INSERT, 48'h0, 8'h01, 1'b1);
    send_request(cpt_pkg::OP_INSERT, 48'hA5A5_5A5A_0F0F, 8'hFF, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'hFFFF_FFFF_FFFF, 8'h80, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'h0, 8'h7F, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'hA5A5_5A5A_0F0F, 8'h01, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_TICK, 48'h0, 8'h00, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'hFFFF_FFFF_FFFF, 8'hC3, 1'b1);
    send_request(cpt_pkg::OP_SIGHT, 48'h5555_5555_5555, 8'h3C, 1'b1);
    send_request(cpt_pkg::OP_NONE, 48'hFFFF_FFFF_FFFF, 8'h80, 1'b1);

    // random phases, each under its own timeout limit; no gaps in the last
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_timeout(limit_plan[p]);
      for (int n = 0; n < PHASE_REQUESTS; n++) random_request(p != PHASES - 1);
    end

    drain();
    repeat (ENTRIES + 4) @(posedge clk);

    $display("%0d requests: %0d sighting hits, %0d misses, %0d ticks, %0d inserts refused",
             tracker.n_requests, tracker.n_hits, tracker.n_misses, tracker.n_ticks,
             tracker.n_refused);
    $display("%0d timeout limits incl. 0, 1 and 127; disconnects %0d, reconnects %0d",
             PHASES + 1, tracker.disc, tracker.recon);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
